// File: sv/pssf_pkg.sv
// Package: types, constants and codes shared by the scanline span fill block.
package pssf_pkg;

  localparam int unsigned MaxVerts   = 32;
  localparam int unsigned CoordBits  = 12;
  localparam int unsigned FracBits   = 12;
  localparam int unsigned MaxSpans   = 16;
  localparam int unsigned ColorBits  = 24;
  localparam int unsigned VidxBits   = $clog2(MaxVerts);
  localparam int unsigned VcntBits   = $clog2(MaxVerts + 1);
  localparam int unsigned CrossBits  = CoordBits + FracBits;
  localparam int unsigned ProdBits   = 2 * CoordBits;
  localparam int unsigned DivBits    = ProdBits + FracBits;
  localparam int unsigned DivCntBits = $clog2(DivBits + 1);
  localparam logic [ColorBits-1:0] ColorReset = '1;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [CoordBits-1:0] vertex_x;
    logic [CoordBits-1:0] vertex_y;
    logic [CoordBits-1:0] scan_line;
  } req_t;

  typedef struct packed {
    logic [CoordBits-1:0] span_y;
    logic [CoordBits-1:0] span_x_begin;
    logic [CoordBits-1:0] span_x_end;
    logic [ColorBits-1:0] span_color;
    logic                 span_valid;
    logic                 last_span;
  } span_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_RANGE_CHK,
    ST_EDGE_RD,
    ST_EDGE,
    ST_MUL,
    ST_DIV,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic clear_list;
    logic append;
    logic latch_line;
    logic range_init;
    logic range_step;
    logic edge_init;
    logic edge_rd;
    logic edge_load;
    logic edge_next;
    logic mul;
    logic div_start;
    logic div_step;
    logic ins_init;
    logic ins_step;
    logic shift_step;
    logic emit_init;
    logic emit_rd;
    logic emit_load;
    logic emit_next;
    logic empty_load;
  } ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic range_done;
    logic in_range;
    logic edges_done;
    logic edge_hit;
    logic div_done;
    logic ins_done;
    logic ins_dup;
    logic ins_full;
    logic shift_done;
    logic emit_done;
    logic no_pairs;
  } stat_t;

endpackage

// File: sv/pssf_ctrl.sv
// Controller: sequences vertex writes, range scan, edge walk, division, insert and emit.
module pssf_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  logic [1:0]     req_type_i,
  input  logic           out_busy_i,
  input  pssf_pkg::stat_t stat_i,
  output pssf_pkg::ctrl_t ctrl_o
);
  import pssf_pkg::*;

  state_e state_q, state_d;
  req_type_e rt;

  assign rt = req_type_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          unique case (rt)
            REQ_ADD:   ctrl_o.append = 1'b1;
            REQ_CLEAR: ctrl_o.clear_list = 1'b1;
            REQ_FILL: begin
              ctrl_o.latch_line = 1'b1;
              ctrl_o.range_init = 1'b1;
              state_d = ST_RANGE;
            end
            default: ;
          endcase
        end
      end
      ST_RANGE: begin
        if (stat_i.range_done) begin
          state_d = ST_RANGE_CHK;
        end else begin
          ctrl_o.range_step = 1'b1;
        end
      end
      ST_RANGE_CHK: begin
        ctrl_o.edge_init = 1'b1;
        ctrl_o.ins_init  = 1'b1;
        state_d = stat_i.in_range ? ST_EDGE_RD : ST_EMIT_RD;
        ctrl_o.emit_init = !stat_i.in_range;
      end
      ST_EDGE_RD: begin
        if (stat_i.edges_done) begin
          ctrl_o.emit_init = 1'b1;
          state_d = ST_EMIT_RD;
        end else begin
          ctrl_o.edge_rd = 1'b1;
          state_d = ST_EDGE;
        end
      end
      ST_EDGE: begin
        ctrl_o.edge_load = 1'b1;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (stat_i.edge_hit) begin
          ctrl_o.mul = 1'b1;
          state_d = ST_DIV;
        end else begin
          ctrl_o.edge_next = 1'b1;
          state_d = ST_EDGE_RD;
        end
      end
      ST_DIV: begin
        if (stat_i.div_done) begin
          ctrl_o.ins_init = 1'b1;
          state_d = ST_INS_SCAN;
        end else begin
          ctrl_o.div_step = 1'b1;
        end
      end
      ST_INS_SCAN: begin
        if (stat_i.ins_dup || stat_i.ins_full) begin
          ctrl_o.edge_next = 1'b1;
          state_d = ST_EDGE_RD;
        end else if (stat_i.ins_done) begin
          state_d = ST_INS_SHIFT;
        end else begin
          ctrl_o.ins_step = 1'b1;
        end
      end
      ST_INS_SHIFT: begin
        ctrl_o.shift_step = 1'b1;
        if (stat_i.shift_done) begin
          ctrl_o.edge_next = 1'b1;
          state_d = ST_EDGE_RD;
        end
      end
      ST_EMIT_RD: begin
        if (stat_i.no_pairs) begin
          state_d = ST_EMPTY;
        end else if (!out_busy_i) begin
          ctrl_o.emit_rd = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        ctrl_o.emit_load = 1'b1;
        ctrl_o.emit_next = 1'b1;
        state_d = stat_i.emit_done ? ST_IDLE : ST_EMIT_RD;
      end
      ST_EMPTY: begin
        if (!out_busy_i) begin
          ctrl_o.empty_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // start the divider on entry to ST_DIV
  // (div_start folded into mul: the product register loads the dividend)
endmodule

// File: sv/pssf_dpath.sv
// Datapath: vertex and crossing memories, range scan, restoring divider, sorted insert, span emit.
module pssf_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pssf_pkg::ctrl_t            ctrl_i,
  output pssf_pkg::stat_t            stat_o,
  input  pssf_pkg::req_t             req_i,
  input  logic [pssf_pkg::ColorBits-1:0] color_i,
  output pssf_pkg::span_t            span_o,
  output logic                       span_load_o
);
  import pssf_pkg::*;

  logic [CoordBits-1:0] vx_mem [MaxVerts];
  logic [CoordBits-1:0] vy_mem [MaxVerts];
  logic [CrossBits-1:0] cx_mem [MaxVerts];

  logic [VcntBits-1:0]  vcnt_q;
  logic [CoordBits-1:0] line_q;
  logic [VcntBits-1:0]  idx_q;
  logic [CoordBits-1:0] miny_q, maxy_q;
  logic                 first_q;
  logic                 rd_ok_q;
  logic [CoordBits-1:0] rdy_q;
  logic [CoordBits-1:0] p1x_q, dx_q, dy_q, dl_q;
  logic                 hit_q;
  logic [DivBits-1:0]   num_q;
  logic [CoordBits:0]   rem_q;
  logic [DivCntBits-1:0] dcnt_q;
  logic [CrossBits-1:0] cand_q;
  logic [VcntBits-1:0]  ccnt_q;
  logic [VcntBits-1:0]  pos_q;
  logic [VcntBits-1:0]  sh_q;
  logic [CrossBits-1:0] cx_rd_q;
  logic [CrossBits-1:0] cx_rd2_q;
  logic [VcntBits-1:0]  eidx_q;
  logic [VcntBits-2:0]  npairs;

  // Vertex memory: one write per cycle while the controller is idle; read at idx, and at idx and idx+1 for edge setup.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.append && vcnt_q < VcntBits'(MaxVerts)) begin
      vx_mem[vcnt_q[VidxBits-1:0]] <= req_i.vertex_x;
      vy_mem[vcnt_q[VidxBits-1:0]] <= req_i.vertex_y;
    end
  end

  always_ff @(posedge clk_i) begin
    rdy_q <= vy_mem[idx_q[VidxBits-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
    end else if (ctrl_i.clear_list) begin
      vcnt_q <= '0;
    end else if (ctrl_i.append && vcnt_q < VcntBits'(MaxVerts)) begin
      vcnt_q <= vcnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch_line) line_q <= req_i.scan_line;
  end

  // Range scan: index advances, read data is registered and arrives in the next cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.range_init) begin
      idx_q   <= '0;
      first_q <= 1'b1;
      rd_ok_q <= 1'b0;
    end else if (ctrl_i.range_step) begin
      rd_ok_q <= idx_q < vcnt_q;
      if (idx_q < vcnt_q) idx_q <= idx_q + 1'b1;
      if (rd_ok_q) begin
        first_q <= 1'b0;
        if (first_q || rdy_q < miny_q) miny_q <= rdy_q;
        if (first_q || rdy_q > maxy_q) maxy_q <= rdy_q;
      end
    end else if (ctrl_i.edge_init) begin
      idx_q <= '0;
    end else if (ctrl_i.edge_load) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  assign stat_o.range_done = (idx_q >= vcnt_q) && !rd_ok_q && !ctrl_i.range_init;
  assign stat_o.in_range   = !first_q && line_q >= miny_q && line_q < maxy_q;
  assign stat_o.edges_done = (idx_q + 1'b1) >= vcnt_q;

  // Edge setup: both end points are read at edge_rd (idx and idx+1).
  logic ord;
  logic [CoordBits-1:0] ex0, ey0, ex1, ey1;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.edge_rd) begin
      ex0 <= vx_mem[idx_q[VidxBits-1:0]];
      ey0 <= vy_mem[idx_q[VidxBits-1:0]];
      ex1 <= vx_mem[VidxBits'(idx_q + 1'b1)];
      ey1 <= vy_mem[VidxBits'(idx_q + 1'b1)];
    end
  end
  logic [CoordBits-1:0] s1x, s1y, s2x, s2y;
  assign ord = ex0 < ex1;
  assign s1x = ord ? ex0 : ex1;
  assign s1y = ord ? ey0 : ey1;
  assign s2x = ord ? ex1 : ex0;
  assign s2y = ord ? ey1 : ey0;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.edge_load) begin
      p1x_q <= s1x;
      dx_q  <= s2x - s1x;
      hit_q <= (s1y != s2y) &&
               ((s1y <= line_q && line_q <= s2y) || (s2y <= line_q && line_q <= s1y));
      if (s2y > s1y) begin
        dy_q <= s2y - s1y;
        dl_q <= line_q - s1y;
      end else begin
        dy_q <= s1y - s2y;
        dl_q <= s1y - line_q;
      end
    end
  end
  assign stat_o.edge_hit = hit_q;

  // Restoring divider, one quotient bit per cycle.
  logic [CoordBits:0] trial;
  assign trial = {rem_q[CoordBits-1:0], num_q[DivBits-1]};
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      num_q  <= {ProdBits'(dl_q) * ProdBits'(dx_q), {FracBits{1'b0}}};
      rem_q  <= '0;
      dcnt_q <= '0;
    end else if (ctrl_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
      if (trial >= {1'b0, dy_q}) begin
        rem_q <= trial - {1'b0, dy_q};
        num_q <= {num_q[DivBits-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        num_q <= {num_q[DivBits-2:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = dcnt_q == DivCntBits'(DivBits);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_init && stat_o.div_done) begin
      cand_q <= {p1x_q, {FracBits{1'b0}}} + num_q[CrossBits-1:0];
    end
  end

  // Sorted insert: scan, then shift, one entry at a time; each entry is read before it is compared or moved.
  logic scan_rd_ok_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccnt_q <= '0;
    end else if (ctrl_i.clear_list || ctrl_i.range_init) begin
      ccnt_q <= '0;
    end else if (ctrl_i.shift_step && stat_o.shift_done) begin
      ccnt_q <= ccnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_rd_q <= cx_mem[pos_q[VidxBits-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins_init) begin
      pos_q        <= '0;
      scan_rd_ok_q <= 1'b0;
    end else if (ctrl_i.ins_step) begin
      if (!scan_rd_ok_q) begin
        scan_rd_ok_q <= 1'b1;
      end else begin
        pos_q        <= pos_q + 1'b1;
        scan_rd_ok_q <= 1'b0;
      end
    end
  end

  logic at_end;
  assign at_end = pos_q >= ccnt_q;
  assign stat_o.ins_done = at_end || (scan_rd_ok_q && cx_rd_q > cand_q);
  assign stat_o.ins_dup  = !at_end && scan_rd_ok_q && cx_rd_q == cand_q;
  assign stat_o.ins_full = stat_o.ins_done && !stat_o.ins_dup &&
                           ccnt_q >= VcntBits'(MaxVerts);

  // Shift from top down: sh runs ccnt..pos; each step moves one entry up.
  logic sh_rd_ok_q;
  logic shift_started_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_started_q <= 1'b0;
    end else if (ctrl_i.shift_step) begin
      shift_started_q <= !(sh_q == pos_q && shift_started_q && sh_rd_ok_q);
    end else begin
      shift_started_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!shift_started_q) begin
      sh_q       <= ccnt_q;
      sh_rd_ok_q <= 1'b0;
    end else if (ctrl_i.shift_step) begin
      if (sh_q == pos_q) begin
        sh_rd_ok_q <= 1'b0;
      end else if (!sh_rd_ok_q) begin
        sh_rd_ok_q <= 1'b1;
      end else begin
        sh_q       <= sh_q - 1'b1;
        sh_rd_ok_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cx_rd2_q <= cx_mem[VidxBits'(sh_q - 1'b1)];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_step && shift_started_q) begin
      if (sh_q == pos_q) begin
        cx_mem[pos_q[VidxBits-1:0]] <= cand_q;
      end else if (sh_rd_ok_q) begin
        cx_mem[sh_q[VidxBits-1:0]] <= cx_rd2_q;
      end
    end
  end
  assign stat_o.shift_done = shift_started_q && sh_q == pos_q;

  // Emit: read two sorted crossings per span.
  logic [CrossBits-1:0] ea_q, eb_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_init) begin
      eidx_q <= '0;
    end else if (ctrl_i.emit_next) begin
      eidx_q <= eidx_q + 1'b1;
    end
    if (ctrl_i.emit_rd) begin
      ea_q <= cx_mem[{eidx_q[VidxBits-2:0], 1'b0}];
      eb_q <= cx_mem[{eidx_q[VidxBits-2:0], 1'b1}];
    end
  end

  assign npairs = (ccnt_q[VcntBits-1:1] > (VcntBits-1)'(MaxSpans)) ?
                  (VcntBits-1)'(MaxSpans) : ccnt_q[VcntBits-1:1];
  assign stat_o.no_pairs  = npairs == '0;
  assign stat_o.emit_done = (eidx_q + 1'b1) == VcntBits'(npairs);

  always_comb begin
    span_o      = '0;
    span_o.span_y = line_q;
    span_load_o = ctrl_i.emit_load || ctrl_i.empty_load;
    if (ctrl_i.emit_load) begin
      span_o.span_x_begin = ea_q[CrossBits-1:FracBits];
      span_o.span_x_end   = eb_q[CrossBits-1:FracBits];
      span_o.span_color   = color_i;
      span_o.span_valid   = 1'b1;
      span_o.last_span    = stat_o.emit_done;
    end else begin
      span_o.last_span    = 1'b1;
    end
  end
endmodule

// File: sv/polygon_scanline_span_fill.sv
// Top level: scanline span filler for an even-odd polygon with a registered result.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------
//  req     | in  | req_valid_i/ready_o   | req_i   (req_type, vertex, scan_line)
//  span    | out | span_valid_o/ready_i  | span_o  (y, x_begin, x_end, color, flags)
//  cfg     | in  | cfg_we_i              | cfg_data_i (fill_color)
//
// Add and clear requests complete in the idle state. A fill request scans all N
// stored vertices, then, if the line is in range, walks each edge between
// consecutive vertices through ST_EDGE_RD, ST_EDGE and ST_MUL; a hit edge adds a
// restoring divide (36 quotient bits) and a sorted insert over the K crossings
// held, each entry read before it is compared or moved in the crossing memory.
// Each span then passes through ST_EMIT_RD and ST_EMIT. Reset is asynchronous
// and clears the control state; the memories need no clearing. The output
// register holds a span while the sink stalls; the controller waits there.
module polygon_scanline_span_fill (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  output logic                           req_ready_o,
  input  pssf_pkg::req_t                 req_i,
  output logic                           span_valid_o,
  input  logic                           span_ready_i,
  output pssf_pkg::span_t                span_o,
  input  logic                           cfg_we_i,
  input  logic [pssf_pkg::ColorBits-1:0] cfg_data_i
);
  import pssf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  span_t span_n;
  logic  span_load;
  logic  out_busy;
  logic [ColorBits-1:0] color_q;
  logic  ovalid_q;
  span_t ospan_q;

  // Hold the fill color; writes must come only while idle, which the block does not enforce.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorReset;
    end else if (cfg_we_i) begin
      color_q <= cfg_data_i;
    end
  end

  // Busy while the output register still holds an untaken span.
  assign out_busy = ovalid_q && !span_ready_i;

  pssf_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .req_valid_i,
    .req_ready_o,
    .req_type_i (req_i.req_type),
    .out_busy_i (out_busy),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pssf_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .req_i,
    .color_i     (color_q),
    .span_o      (span_n),
    .span_load_o (span_load)
  );

  // Output register: load a new span, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (span_load) begin
      ovalid_q <= 1'b1;
    end else if (span_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (span_load) ospan_q <= span_n;
  end

  assign span_valid_o = ovalid_q;
  assign span_o       = ospan_q;
endmodule

// File: sv/pssf_checker.sv
// Port checker for the scanline span fill block, bound to the top level.
module pssf_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_o,
  input pssf_pkg::req_t  req_i,
  input logic            span_valid_o,
  input logic            span_ready_i,
  input pssf_pkg::span_t span_o
);
  import pssf_pkg::*;

  ap_span_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o && !span_ready_i |=> span_valid_o && $stable(span_o))
    else $error("span changed while stalled");

  ap_busy_after_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o && req_i.req_type == REQ_FILL |=> !req_ready_o)
    else $error("request taken during fill");

  ap_invalid_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_valid_o && !span_o.span_valid |-> span_o.last_span)
    else $error("empty result not marked last");

  ap_no_out_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o && !$past(req_ready_o) |-> $past(span_valid_o) || span_valid_o)
    else $error("fill ended without result");
endmodule

bind polygon_scanline_span_fill pssf_checker u_pssf_checker (.*);
